### src/skt_pkg.sv
// Shared constants and types of the sorted key table.
// No dependencies; every other file of the block imports this package.
package skt_pkg;

  localparam int SKT_DEPTH_DEF = 256;
  localparam int SKT_KEY_W_DEF = 32;
  localparam int CMD_W         = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_FIND   = 3'd1,
    CMD_READ   = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_WRITE  = 3'd4,
    CMD_APPEND = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_FINAL_RD,
    ST_FINAL_CMP,
    ST_READ_WAIT,
    ST_SHIFT,
    ST_DONE
  } state_t;

endpackage

### src/skt_if.sv
// Handshake channel interfaces of the sorted key table: command, result, config.
// Depends on skt_pkg for the default widths.
interface skt_in_if import skt_pkg::*; #(
  parameter int KEY_W = SKT_KEY_W_DEF,
  parameter int CNT_W = $clog2(SKT_DEPTH_DEF + 1)
) ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [KEY_W-1:0] key;
  logic [CNT_W-1:0] position;
  logic [CNT_W-1:0] run_length;

  modport source (output valid, command, key, position, run_length, input ready);
  modport sink   (input valid, command, key, position, run_length, output ready);
endinterface

interface skt_out_if import skt_pkg::*; #(
  parameter int KEY_W = SKT_KEY_W_DEF,
  parameter int POS_W = $clog2(SKT_DEPTH_DEF),
  parameter int CNT_W = $clog2(SKT_DEPTH_DEF + 1)
) ();
  logic             valid;
  logic             ready;
  logic             ok;
  logic [POS_W-1:0] found_position;
  logic [KEY_W-1:0] read_value;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, ok, found_position, read_value, entry_count, input ready);
  modport sink   (input valid, ok, found_position, read_value, entry_count, output ready);
endinterface

interface skt_cfg_if;
  logic valid;
  logic ready;
  logic keep_sorted;

  modport source (output valid, keep_sorted, input ready);
  modport sink   (input valid, keep_sorted, output ready);
endinterface

### src/skt_mem.sv
// Key storage of the sorted key table: one write port, one registered read port.
// Depends on skt_pkg for default sizes.
module skt_mem import skt_pkg::*; #(
  parameter int DEPTH = SKT_DEPTH_DEF,
  parameter int WIDTH = SKT_KEY_W_DEF,
  parameter int AW    = $clog2(SKT_DEPTH_DEF)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/skt_ctrl.sv
// Command sequencer of the sorted key table: halving search, shifts, result register.
// Depends on skt_pkg, skt_if and skt_mem.
module skt_ctrl import skt_pkg::*; #(
  parameter int TABLE_DEPTH = SKT_DEPTH_DEF,
  parameter int KEY_WIDTH   = SKT_KEY_W_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       keep_sorted,
  skt_in_if.sink     in_ch,
  skt_out_if.source  out_ch
);

  localparam int POS_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  state_t               state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic [CNT_W-1:0]     len_r, len_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     step_r, step_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [POS_W-1:0]     probe_r, probe_nxt;
  logic [CNT_W-1:0]     src_r, src_nxt;
  logic [CNT_W-1:0]     mcnt_r, mcnt_nxt;
  logic                 pend_r, pend_nxt;
  logic [POS_W-1:0]     pend_addr_r, pend_addr_nxt;
  logic                 res_ok_r, res_ok_nxt;
  logic [POS_W-1:0]     res_fpos_r, res_fpos_nxt;
  logic [KEY_WIDTH-1:0] res_val_r, res_val_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r;
  logic [POS_W-1:0]     out_fpos_r;
  logic [KEY_WIDTH-1:0] out_val_r;
  logic [CNT_W-1:0]     out_cnt_r;
  logic                 load;

  logic                 mem_we;
  logic [POS_W-1:0]     mem_waddr;
  logic [KEY_WIDTH-1:0] mem_wdata;
  logic [POS_W-1:0]     mem_raddr;
  logic [KEY_WIDTH-1:0] mem_rdata;

  logic [CNT_W:0]       probe_sum;
  logic [CNT_W:0]       last_idx;
  logic [CNT_W:0]       probe_min;
  logic [CNT_W:0]       del_end;
  logic [CNT_W-1:0]     probe_next;
  logic [CNT_W-1:0]     ins_idx;
  logic [CNT_W-1:0]     find_idx;
  cmd_t                 in_cmd;

  skt_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (KEY_WIDTH),
    .AW    (POS_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_cmd     = cmd_t'(in_ch.command);
  assign probe_sum  = {1'b0, idx_r} + {1'b0, step_r};
  assign last_idx   = {1'b0, count_r} - (CNT_W+1)'(1);
  assign probe_min  = (probe_sum < last_idx) ? probe_sum : last_idx;
  assign del_end    = {1'b0, in_ch.position} + {1'b0, in_ch.run_length};
  assign probe_next = CNT_W'(probe_r) + CNT_W'(1);
  assign ins_idx    = (key_r >= mem_rdata) ? probe_next : idx_r;
  assign find_idx   = (key_r > mem_rdata) ? probe_next : idx_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign load        = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    len_nxt       = len_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    probe_nxt     = probe_r;
    src_nxt       = src_r;
    mcnt_nxt      = mcnt_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    res_ok_nxt    = res_ok_r;
    res_fpos_nxt  = res_fpos_r;
    res_val_nxt   = res_val_r;
    mem_we        = 1'b0;
    mem_waddr     = pos_r[POS_W-1:0];
    mem_wdata     = key_r;
    mem_raddr     = probe_r;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt      = in_cmd;
          key_nxt      = in_ch.key;
          pos_nxt      = in_ch.position;
          len_nxt      = in_ch.run_length;
          res_ok_nxt   = 1'b0;
          res_fpos_nxt = '0;
          res_val_nxt  = '0;
          step_nxt     = count_r >> 1;
          idx_nxt      = '0;
          pend_nxt     = 1'b0;
          state_nxt    = ST_DONE;
          case (in_cmd)
            CMD_INSERT: begin
              if (count_r != DEPTH_C) begin
                if (!keep_sorted || count_r == '0) begin
                  // Append: the shift stage has nothing to move.
                  idx_nxt   = count_r;
                  mcnt_nxt  = '0;
                  state_nxt = ST_SHIFT;
                end else begin
                  state_nxt = ST_PROBE;
                end
              end
            end
            CMD_FIND: begin
              if (keep_sorted && count_r != '0) begin
                state_nxt = ST_PROBE;
              end
            end
            CMD_READ: begin
              if (in_ch.position < count_r) begin
                mem_raddr = in_ch.position[POS_W-1:0];
                state_nxt = ST_READ_WAIT;
              end
            end
            CMD_DELETE: begin
              if (del_end <= {1'b0, count_r}) begin
                src_nxt   = del_end[CNT_W-1:0];
                mcnt_nxt  = (in_ch.run_length == '0) ? '0 : count_r - del_end[CNT_W-1:0];
                state_nxt = ST_SHIFT;
              end
            end
            CMD_WRITE: begin
              mem_waddr = in_ch.position[POS_W-1:0];
              mem_wdata = in_ch.key;
              if (in_ch.position < count_r) begin
                mem_we     = 1'b1;
                res_ok_nxt = 1'b1;
              end else if (in_ch.position == count_r && count_r != DEPTH_C) begin
                mem_we     = 1'b1;
                res_ok_nxt = 1'b1;
                count_nxt  = count_r + CNT_W'(1);
              end
            end
            CMD_APPEND: begin
              if (count_r != DEPTH_C) begin
                mem_we     = 1'b1;
                mem_waddr  = count_r[POS_W-1:0];
                mem_wdata  = in_ch.key;
                res_ok_nxt = 1'b1;
                count_nxt  = count_r + CNT_W'(1);
              end
            end
            default: ;
          endcase
        end
      end
      ST_PROBE: begin
        probe_nxt = probe_min[POS_W-1:0];
        mem_raddr = probe_min[POS_W-1:0];
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        step_nxt = step_r >> 1;
        if (cmd_r == CMD_INSERT) begin
          idx_nxt = ins_idx;
          if (step_r == '0) begin
            src_nxt   = count_r - CNT_W'(1);
            mcnt_nxt  = count_r - ins_idx;
            state_nxt = ST_SHIFT;
          end else begin
            state_nxt = ST_PROBE;
          end
        end else if (key_r == mem_rdata) begin
          res_ok_nxt   = 1'b1;
          res_fpos_nxt = probe_r;
          state_nxt    = ST_DONE;
        end else begin
          idx_nxt   = find_idx;
          state_nxt = (step_r == '0) ? ST_FINAL_RD : ST_PROBE;
        end
      end
      ST_FINAL_RD: begin
        // The search can end one past the last entry; clamp it back.
        probe_nxt = (idx_r == count_r) ? last_idx[POS_W-1:0] : idx_r[POS_W-1:0];
        mem_raddr = probe_nxt;
        state_nxt = ST_FINAL_CMP;
      end
      ST_FINAL_CMP: begin
        if (key_r == mem_rdata) begin
          res_ok_nxt   = 1'b1;
          res_fpos_nxt = probe_r;
        end
        state_nxt = ST_DONE;
      end
      ST_READ_WAIT: begin
        res_ok_nxt  = 1'b1;
        res_val_nxt = mem_rdata;
        state_nxt   = ST_DONE;
      end
      ST_SHIFT: begin
        // One entry read per cycle; the entry read last cycle is written now.
        mem_raddr = src_r[POS_W-1:0];
        mem_wdata = mem_rdata;
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = (cmd_r == CMD_INSERT) ? pend_addr_r + POS_W'(1)
                                            : pend_addr_r - len_r[POS_W-1:0];
        end
        if (mcnt_r != '0) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = src_r[POS_W-1:0];
          src_nxt       = (cmd_r == CMD_INSERT) ? src_r - CNT_W'(1) : src_r + CNT_W'(1);
          mcnt_nxt      = mcnt_r - CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            res_ok_nxt = 1'b1;
            state_nxt  = ST_DONE;
            if (cmd_r == CMD_INSERT) begin
              mem_we       = 1'b1;
              mem_waddr    = idx_r[POS_W-1:0];
              mem_wdata    = key_r;
              res_fpos_nxt = idx_r[POS_W-1:0];
              count_nxt    = count_r + CNT_W'(1);
            end else begin
              count_nxt = count_r - len_r;
            end
          end
        end
      end
      ST_DONE: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ch.ready) || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    pos_r       <= pos_nxt;
    len_r       <= len_nxt;
    step_r      <= step_nxt;
    idx_r       <= idx_nxt;
    probe_r     <= probe_nxt;
    src_r       <= src_nxt;
    mcnt_r      <= mcnt_nxt;
    pend_addr_r <= pend_addr_nxt;
    res_ok_r    <= res_ok_nxt;
    res_fpos_r  <= res_fpos_nxt;
    res_val_r   <= res_val_nxt;
    if (load) begin
      out_ok_r   <= res_ok_r;
      out_fpos_r <= res_fpos_r;
      out_val_r  <= res_val_r;
      out_cnt_r  <= count_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.ok             = out_ok_r;
  assign out_ch.found_position = out_fpos_r;
  assign out_ch.read_value     = out_val_r;
  assign out_ch.entry_count    = out_cnt_r;

endmodule

### src/sorted_key_table.sv
// Top level of the sorted key table: configuration register and command sequencer.
// Depends on skt_pkg, skt_if, skt_mem and skt_ctrl.
//
//   Channel  Direction  Carries
//   in_ch    sink       command, key, position, run_length
//   out_ch   source     ok, found_position, read_value, entry_count
//   cfg_ch   sink       keep_sorted
//
// One item is processed at a time. Write, append and rejected commands go straight
// to the result stage, and a read goes by way of one memory read. A sorted search
// reads and compares one probe per halving step; insert and delete then move one
// entry per cycle through the key memory. Reset clears the entry count and all
// handshake state; key memory contents are left as they are. A result waiting on
// out_ch does not block taking the next item, but holds that item's result back.
module sorted_key_table import skt_pkg::*; #(
  parameter int TABLE_DEPTH = SKT_DEPTH_DEF,
  parameter int KEY_WIDTH   = SKT_KEY_W_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  skt_in_if.sink    in_ch,
  skt_out_if.source out_ch,
  skt_cfg_if.sink   cfg_ch
);

  // Sorting mode: on after reset, so inserts are ordered and find is enabled.
  logic keep_sorted_r, keep_sorted_nxt;

  // The register is always free to be written.
  assign cfg_ch.ready    = 1'b1;
  assign keep_sorted_nxt = cfg_ch.valid ? cfg_ch.keep_sorted : keep_sorted_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_sorted_r <= 1'b1;
    end else begin
      keep_sorted_r <= keep_sorted_nxt;
    end
  end

  // The sequencer owns the key memory, the entry count and the result register.
  skt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .keep_sorted (keep_sorted_r),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

endmodule
